// ----- rtl/bit_pattern_find_replace_defines.svh -----
// ----------------------------------------------------------------------------
// Bit pattern find/replace assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BIT_PATTERN_FIND_REPLACE_DEFINES_SVH
`define BIT_PATTERN_FIND_REPLACE_DEFINES_SVH

// check in the same cycle
`define BPFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check in the following cycle
`define BPFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit pattern find/replace package
// Register indexes, widths and the result job passed to the output stage.
// ----------------------------------------------------------------------------
package bpfr_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = 7;
    localparam int REG_W       = 64;
    localparam int JOB_W       = 64;
    localparam int IDX_W       = 6;
    localparam int POS_W       = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int REP_MAX     = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_BITS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLACE_BITS   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLACE_LENGTH = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLACE_MODE   = 3'd4;

    typedef struct packed {
        logic [JOB_W-1:0] bits;
        logic [IDX_W-1:0] top;
        logic [LEN_W-1:0] cnt;
        logic             report;
        logic             found;
        logic [POS_W-1:0] loc;
    } t_job;

endpackage

// ----- rtl/bpfr_cell.sv -----
// ----------------------------------------------------------------------------
// Bit pattern find/replace window cell
// Holds one window bit and compares the bit arriving from its neighbor.
// ----------------------------------------------------------------------------
module bpfr_cell (
    input  logic i_clk,
    input  logic i_shift,
    input  logic i_bit,
    input  logic i_pat,
    input  logic i_active,
    output logic o_bit,
    output logic o_eq
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_bit <= i_bit;
        end
    end

    assign o_bit = r_bit;
    assign o_eq  = !i_active || (i_bit == i_pat);

endmodule

// ----- rtl/bpfr_chain.sv -----
// ----------------------------------------------------------------------------
// Bit pattern find/replace cell chain
// Row of window cells; newest bit enters cell 0 and moves up one per transfer.
// ----------------------------------------------------------------------------
module bpfr_chain #(
    parameter int MAX_PATTERN = bpfr_pkg::PATTERN_MAX
) (
    input  logic                    i_clk,
    input  logic                    i_shift,
    input  logic                    i_in_bit,
    input  logic [MAX_PATTERN-1:0]  i_pattern,
    input  logic [bpfr_pkg::LEN_W-1:0] i_len,
    output logic [MAX_PATTERN-1:0]  o_next,
    output logic                    o_hit
);

    import bpfr_pkg::*;

    logic [MAX_PATTERN-1:0] w_q;
    logic [MAX_PATTERN-1:0] w_d;
    logic [MAX_PATTERN-1:0] w_eq;

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign w_d[i] = i_in_bit;
        end else begin : g_body
            assign w_d[i] = w_q[i-1];
        end

        bpfr_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (i_shift),
            .i_bit    (w_d[i]),
            .i_pat    (i_pattern[i]),
            .i_active (LEN_W'(i) < i_len),
            .o_bit    (w_q[i]),
            .o_eq     (w_eq[i])
        );
    end

    assign o_next = w_d;
    assign o_hit  = &w_eq;

endmodule

// ----- rtl/bpfr_emit.sv -----
// ----------------------------------------------------------------------------
// Bit pattern find/replace output stage
// Holds one input transfer's results, sent one per cycle under i_ready.
// ----------------------------------------------------------------------------
`include "bit_pattern_find_replace_defines.svh"

module bpfr_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  bpfr_pkg::t_job        i_job,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_out_bit,
    output logic                  o_bit_valid,
    output logic                  o_match_found,
    output logic [bpfr_pkg::POS_W-1:0] o_match_location,
    output logic                  o_run_last
);

    import bpfr_pkg::*;

    t_job r_job;
    logic w_xfer;

    assign o_valid = (r_job.cnt != '0);
    assign w_xfer  = o_valid && i_ready;
    assign o_ready = (r_job.cnt == '0) || ((r_job.cnt == LEN_W'(1)) && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job.cnt   <= '0;
            r_job.found <= 1'b0;
        end else if (i_load) begin
            r_job <= i_job;
        end else if (w_xfer) begin
            r_job.cnt   <= r_job.cnt - LEN_W'(1);
            r_job.top   <= r_job.top - IDX_W'(1);
            r_job.found <= 1'b0;
        end
    end

    assign o_bit_valid      = !r_job.report;
    assign o_out_bit        = !r_job.report && r_job.bits[r_job.top];
    assign o_match_found    = r_job.found;
    assign o_match_location = r_job.found ? r_job.loc : '0;
    assign o_run_last       = (r_job.cnt == LEN_W'(1));

    `BPFR_ASSERT_SAME(a_report_single, r_job.report && o_valid, r_job.cnt == LEN_W'(1), "report job holds more than one result")
    `BPFR_ASSERT_SAME(a_top_covers, o_valid, {1'b0, r_job.top} >= (r_job.cnt - LEN_W'(1)), "bit index below remaining count")
    `BPFR_ASSERT_NEXT(a_found_first, w_xfer && !i_load && (r_job.cnt > LEN_W'(1)), !r_job.found, "match flag beyond first result")

endmodule

// ----- rtl/bit_pattern_find_replace.sv -----
// ----------------------------------------------------------------------------
// Bit pattern find/replace
// Serial search of a configured bit pattern with optional stream rewrite.
//
//   Channel   Dir  Fields (low bit up)
//   s_axis    in   tdata: in_bit, 7 zero bits; tlast: stream_last
//   m_axis    out  tdata: out_bit, match_location, 7 zero bits;
//                  tuser: bit_valid, match_found; tlast: run_last
//   cfg       in   i_cfg_addr selects the register, i_cfg_wdata its value
//
// One input bit is taken per cycle while each bit gives at most one result and
// output is ready. A match with replacement bits or a flush at stream end gives
// up to 64 results, sent one per cycle while output is ready; input waits until
// the last one transfers. Results appear the cycle after their input transfer.
// Reset is synchronous; it clears window state and restores register defaults.
// ----------------------------------------------------------------------------
`include "bit_pattern_find_replace_defines.svh"

module bit_pattern_find_replace #(
    parameter int MAX_PATTERN = bpfr_pkg::PATTERN_MAX
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bpfr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bpfr_pkg::REG_W-1:0]     i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // in_bit
    input  logic                           s_axis_tlast,  // stream_last
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,  // out_bit, match_location
    output logic [1:0]                     m_axis_tuser,  // bit_valid, match_found
    output logic                           m_axis_tlast   // run_last
);

    import bpfr_pkg::*;

    logic [REG_W-1:0] r_pat_bits;
    logic [LEN_W-1:0] r_pat_len;
    logic [REG_W-1:0] r_rep_bits;
    logic [LEN_W-1:0] r_rep_len;
    logic             r_rep_mode;

    logic [LEN_W-1:0] r_fill;
    logic [POS_W-1:0] r_pos;
    logic [LEN_W-1:0] n_fill;
    logic [POS_W-1:0] n_pos;

    logic                   w_accept;
    logic                   w_last;
    logic [LEN_W-1:0]       w_len;
    logic [LEN_W-1:0]       w_rlen;
    logic [LEN_W-1:0]       w_f0;
    logic [LEN_W-1:0]       w_f1;
    logic [LEN_W-1:0]       w_drop;
    logic [LEN_W:0]         w_step;
    logic                   w_cmp;
    logic                   w_hit;
    logic                   w_match;
    logic [POS_W-1:0]       w_loc;
    logic [MAX_PATTERN-1:0] w_next;
    logic [JOB_W-1:0]       w_next_ext;
    t_job                   w_job;

    logic       w_bit_valid;
    logic       w_match_found;
    logic       w_out_bit;
    logic [POS_W-1:0] w_match_loc;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_last   = s_axis_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bits <= '0;
            r_pat_len  <= LEN_W'(1);
            r_rep_bits <= '0;
            r_rep_len  <= '0;
            r_rep_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_PATTERN_BITS:   r_pat_bits <= i_cfg_wdata;
                CFG_PATTERN_LENGTH: r_pat_len  <= i_cfg_wdata[LEN_W-1:0];
                CFG_REPLACE_BITS:   r_rep_bits <= i_cfg_wdata;
                CFG_REPLACE_LENGTH: r_rep_len  <= i_cfg_wdata[LEN_W-1:0];
                CFG_REPLACE_MODE:   r_rep_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_pat_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(MAX_PATTERN)) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = r_pat_len;
        end
        w_rlen = (r_rep_len > LEN_W'(REP_MAX)) ? LEN_W'(REP_MAX) : r_rep_len;
    end

    bpfr_chain #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_chain (
        .i_clk     (i_clk),
        .i_shift   (w_accept),
        .i_in_bit  (s_axis_tdata[0]),
        .i_pattern (r_pat_bits[MAX_PATTERN-1:0]),
        .i_len     (w_len),
        .o_next    (w_next),
        .o_hit     (w_hit)
    );

    always_comb begin
        w_next_ext = '0;
        w_next_ext[MAX_PATTERN-1:0] = w_next;

        // drop oldest bits beyond the pattern length
        w_f0 = (r_fill > w_len) ? w_len : r_fill;
        if (w_f0 == w_len) begin
            w_f1   = w_len;
            w_drop = (r_fill - w_f0) + LEN_W'(1);
        end else begin
            w_f1   = w_f0 + LEN_W'(1);
            w_drop = r_fill - w_f0;
        end
        w_loc   = r_pos + POS_W'(w_drop);
        w_cmp   = (w_f1 == w_len);
        w_match = w_cmp && w_hit;

        w_job        = '0;
        w_job.bits   = w_next_ext;
        w_job.loc    = w_loc;
        if (w_match && r_rep_mode && (w_rlen != '0)) begin
            w_job.bits  = r_rep_bits;
            w_job.top   = IDX_W'(w_rlen - LEN_W'(1));
            w_job.cnt   = w_rlen;
            w_job.found = 1'b1;
        end else if (w_match) begin
            w_job.bits   = '0;
            w_job.cnt    = LEN_W'(1);
            w_job.report = 1'b1;
            w_job.found  = 1'b1;
        end else if (r_rep_mode && w_cmp) begin
            w_job.top = IDX_W'(w_len - LEN_W'(1));
            w_job.cnt = w_last ? w_len : LEN_W'(1);
        end else if (r_rep_mode && w_last) begin
            w_job.top = IDX_W'(w_f1 - LEN_W'(1));
            w_job.cnt = w_f1;
        end

        if (w_match) begin
            w_step = {1'b0, w_drop} + {1'b0, w_len};
        end else if (w_cmp) begin
            w_step = {1'b0, w_drop} + (LEN_W+1)'(1);
        end else begin
            w_step = {1'b0, w_drop};
        end

        if (w_last) begin
            n_fill = '0;
            n_pos  = '0;
        end else begin
            n_pos = r_pos + POS_W'(w_step);
            if (w_match) begin
                n_fill = '0;
            end else if (w_cmp) begin
                n_fill = w_len - LEN_W'(1);
            end else begin
                n_fill = w_f1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
            r_pos  <= n_pos;
        end
    end

    bpfr_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_accept),
        .i_job            (w_job),
        .o_ready          (s_axis_tready),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_out_bit        (w_out_bit),
        .o_bit_valid      (w_bit_valid),
        .o_match_found    (w_match_found),
        .o_match_location (w_match_loc),
        .o_run_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, w_match_loc, w_out_bit};
    assign m_axis_tuser = {w_match_found, w_bit_valid};

    `BPFR_ASSERT_SAME(a_fill_range, 1'b1, r_fill <= LEN_W'(MAX_PATTERN), "fill count above window size")
    `BPFR_ASSERT_NEXT(a_last_restart, w_accept && w_last, (r_fill == '0) && (r_pos == '0), "stream end did not restart window")
    `BPFR_ASSERT_NEXT(a_match_clear, w_accept && w_match, r_fill == '0, "window not emptied after match")

endmodule
